FILE: rtl/core/bitplane_significance_decoder_assert.svh
// Assertion macros for the bit-plane significance decoder.
// Used by the RTL files that check their own control logic; needs clk and rst_n in scope.
`ifndef BITPLANE_SIGNIFICANCE_DECODER_ASSERT_SVH
`define BITPLANE_SIGNIFICANCE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define BSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsd: implication check failed");
// Next-cycle implication, checked out of reset
`define BSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsd: next-cycle check failed");
`else
`define BSD_ASSERT_IMP(lbl, ante, cons)
`define BSD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/bsd_pkg.sv
// Shared types and constants of the bit-plane significance decoder.
// No dependencies; the other RTL files all use it, but for the assertion header.
`default_nettype none
package bsd_pkg;

  localparam int DEPTH_DEF    = 4096;
  localparam int MAG_BITS_DEF = 16;

  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 12;
  localparam int VALUE_W  = 17;
  localparam int EXPECT_W = 2;
  localparam int POS_W    = 13;
  localparam int COUNT_W  = 13;
  localparam int PLANE_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BIT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

  // How the next bit is taken
  localparam logic [EXPECT_W-1:0] EXP_SIG  = 2'd0;
  localparam logic [EXPECT_W-1:0] EXP_SIGN = 2'd1;
  localparam logic [EXPECT_W-1:0] EXP_REF  = 2'd2;
  localparam logic [EXPECT_W-1:0] EXP_NONE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PLANE   = 1'd1;

  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = 13'd4;
  localparam logic [PLANE_W-1:0] BIT_PLANE_RST   = 4'd0;

  typedef struct packed {
    logic [COUNT_W-1:0] entry_count;
    logic [PLANE_W-1:0] bit_plane;
  } bsd_cfg_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [EXPECT_W-1:0]       expect_res;
    logic [POS_W-1:0]          position;
  } bsd_result_t;

endpackage
`default_nettype wire

FILE: rtl/core/bsd_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on bsd_pkg for field widths.
`default_nettype none
interface bsd_in_if;
  logic                          valid;
  logic                          ready;
  logic [bsd_pkg::MODE_W-1:0]    mode;
  logic                          bit_req;
  logic [bsd_pkg::INDEX_W-1:0]   index;

  modport source (output valid, mode, bit_req, index, input ready);
  modport sink   (input valid, mode, bit_req, index, output ready);
endinterface

interface bsd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bsd_pkg::VALUE_W-1:0]  value;
  logic [bsd_pkg::EXPECT_W-1:0]        expect_res;
  logic [bsd_pkg::POS_W-1:0]           position;

  modport source (output valid, value, expect_res, position, input ready);
  modport sink   (input valid, value, expect_res, position, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bsd_store.sv
// Coefficient store: one write port and one read port, registered read data.
// Depends on bsd_pkg for its parameter defaults.
`default_nettype none
module bsd_store #(
  parameter int DEPTH = bsd_pkg::DEPTH_DEF,
  parameter int WIDTH = bsd_pkg::MAG_BITS_DEF + 3
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);
  import bsd_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: rtl/core/bsd_ctrl.sv
// Pass sequencer: read-modify-write of the coefficient store, entry walks,
// clearing sweep and read-out. Depends on bsd_pkg, bsd_if, bsd_store and the assertion header.
`default_nettype none
`include "bitplane_significance_decoder_assert.svh"
module bsd_ctrl #(
  parameter int DEPTH    = bsd_pkg::DEPTH_DEF,
  parameter int MAG_BITS = bsd_pkg::MAG_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bsd_pkg::bsd_cfg_t cfg,
  bsd_in_if.sink                 in_ch,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output bsd_pkg::bsd_result_t   res
);
  import bsd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = MAG_BITS + 3;
  localparam logic [EW-1:0] SGN_FLAG = EW'(1) << MAG_BITS;
  localparam logic [EW-1:0] SIG_FLAG = EW'(1) << (MAG_BITS + 1);
  localparam logic [EW-1:0] REF_FLAG = EW'(1) << (MAG_BITS + 2);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_BIT   = 7'b0000100,
    ST_WALK  = 7'b0001000,
    ST_CHK   = 7'b0010000,
    ST_READ  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_SIG  = 4'b0010,
    PH_SIGN = 4'b0100,
    PH_REF  = 4'b1000
  } phase_t;

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [CW-1:0]       cursor_r, cursor_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic                clr_item_r, clr_item_nxt;
  logic [VALUE_W-1:0]  value_r, value_nxt;
  logic                bit_r, bit_nxt;

  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [EW-1:0]       rd_data, wr_data;

  logic [CW-1:0]       n_cnt;
  logic                cursor_ge;
  logic [AW-1:0]       cur_addr;
  logic [31:0]         idx32;
  logic [31:0]         cur32;
  logic [MAG_BITS-1:0] plane_bit;
  logic signed [MAG_BITS+1:0] sval;
  logic signed [31:0]  sval32;

  bsd_store #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Pass length, clipped to the store depth
  always_comb begin
    if (32'(cfg.entry_count) > DEPTH) begin
      n_cnt = CW'(DEPTH);
    end else begin
      n_cnt = CW'(cfg.entry_count);
    end
  end

  assign cursor_ge = (cursor_r >= n_cnt);
  assign cur_addr  = cursor_r[AW-1:0];
  assign idx32     = 32'(in_ch.index);
  assign cur32     = 32'(cursor_r);

  // Magnitude bit for the configured plane; planes past the magnitude drop
  always_comb begin
    if ((32'(cfg.bit_plane) < MAG_BITS) && bit_r) begin
      plane_bit = MAG_BITS'(1) << cfg.bit_plane;
    end else begin
      plane_bit = '0;
    end
  end

  // Sign-magnitude to two's complement
  always_comb begin
    sval = $signed({2'b00, rd_data[MAG_BITS-1:0]});
    if (rd_data[MAG_BITS]) begin
      sval = -sval;
    end
    sval32 = 32'(sval);
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    cursor_nxt   = cursor_r;
    clr_addr_nxt = clr_addr_r;
    clr_item_nxt = clr_item_r;
    value_nxt    = value_r;
    bit_nxt      = bit_r;
    rd_en        = 1'b0;
    rd_addr      = cur_addr;
    wr_en        = 1'b0;
    wr_addr      = cur_addr;
    wr_data      = rd_data;
    in_ch.ready  = 1'b0;
    res_valid    = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
        if (clr_addr_r == LAST_ADDR) begin
          clr_addr_nxt = '0;
          clr_item_nxt = 1'b0;
          state_nxt    = clr_item_r ? ST_EMIT : ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end

      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          value_nxt = '0;
          bit_nxt   = in_ch.bit_req;
          case (in_ch.mode)
            MODE_START: begin
              phase_nxt  = PH_SIG;
              cursor_nxt = '0;
              state_nxt  = ST_WALK;
            end
            MODE_BIT: begin
              if ((phase_r != PH_IDLE) && cursor_ge) begin
                // cursor ran past a shortened count: resume the walk
                if (phase_r != PH_REF) begin
                  phase_nxt = PH_SIG;
                end
                state_nxt = ST_WALK;
              end else if (phase_r == PH_IDLE) begin
                state_nxt = ST_EMIT;
              end else begin
                rd_en     = 1'b1;
                state_nxt = ST_BIT;
              end
            end
            MODE_READ: begin
              if (idx32 < DEPTH) begin
                rd_en     = 1'b1;
                rd_addr   = idx32[AW-1:0];
                state_nxt = ST_READ;
              end else begin
                state_nxt = ST_EMIT;
              end
            end
            MODE_CLEAR: begin
              phase_nxt    = PH_IDLE;
              cursor_nxt   = '0;
              clr_addr_nxt = '0;
              clr_item_nxt = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      // Apply the supplied bit to the entry under the cursor
      ST_BIT: begin
        wr_en = 1'b1;
        case (phase_r)
          PH_SIG: begin
            wr_data = rd_data | {3'b000, plane_bit};
            if (bit_r) begin
              phase_nxt = PH_SIGN;
              state_nxt = ST_EMIT;
            end else begin
              cursor_nxt = cursor_r + CW'(1);
              state_nxt  = ST_WALK;
            end
          end
          PH_SIGN: begin
            wr_data    = rd_data | SIG_FLAG | (bit_r ? SGN_FLAG : '0);
            phase_nxt  = PH_SIG;
            cursor_nxt = cursor_r + CW'(1);
            state_nxt  = ST_WALK;
          end
          PH_REF: begin
            wr_data    = rd_data | {3'b000, plane_bit};
            cursor_nxt = cursor_r + CW'(1);
            state_nxt  = ST_WALK;
          end
          default: begin
            wr_en     = 1'b0;
            state_nxt = ST_EMIT;
          end
        endcase
      end

      // Advance to the next entry that needs a bit, or close the sub-pass
      ST_WALK: begin
        if (cursor_ge) begin
          if (phase_r == PH_SIG) begin
            phase_nxt  = PH_REF;
            cursor_nxt = '0;
          end else begin
            phase_nxt  = PH_IDLE;
            cursor_nxt = n_cnt;
            state_nxt  = ST_EMIT;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_CHK;
        end
      end

      ST_CHK: begin
        if (phase_r == PH_SIG) begin
          // skip refining entries
          if ((rd_data & REF_FLAG) != '0) begin
            cursor_nxt = cursor_r + CW'(1);
            state_nxt  = ST_WALK;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else begin
          if ((rd_data & REF_FLAG) != '0) begin
            state_nxt = ST_EMIT;
          end else begin
            // promote newly significant entries
            if ((rd_data & SIG_FLAG) != '0) begin
              wr_en   = 1'b1;
              wr_data = rd_data ^ (SIG_FLAG | REF_FLAG);
            end
            cursor_nxt = cursor_r + CW'(1);
            state_nxt  = ST_WALK;
          end
        end
      end

      ST_READ: begin
        value_nxt = sval32[VALUE_W-1:0];
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result fields
  always_comb begin
    res.value    = $signed(value_r);
    res.position = cur32[POS_W-1:0];
    case (phase_r)
      PH_SIG:  res.expect_res = EXP_SIG;
      PH_SIGN: res.expect_res = EXP_SIGN;
      PH_REF:  res.expect_res = EXP_REF;
      default: res.expect_res = EXP_NONE;
    endcase
  end

  // State registers; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      phase_r    <= PH_IDLE;
      cursor_r   <= '0;
      clr_addr_r <= '0;
      clr_item_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      cursor_r   <= cursor_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_item_r <= clr_item_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    bit_r   <= bit_nxt;
  end

  // A read never targets the entry being written in the same cycle
  `BSD_ASSERT_IMP(a_no_rw_collide, rd_en && wr_en, rd_addr != wr_addr)
  // A clear item starts the sweep in the next cycle
  `BSD_ASSERT_NXT(a_clear_sweeps,
    in_ch.valid && in_ch.ready && (in_ch.mode == MODE_CLEAR), state_r == ST_CLEAR)
  // A delivered result frees the sequencer for the next item
  `BSD_ASSERT_NXT(a_emit_frees, res_valid && res_ready, in_ch.ready)

endmodule
`default_nettype wire

FILE: rtl/core/bitplane_significance_decoder.sv
// Bit-plane significance decoder: bsd_ctrl walks a one-port-read, one-port-write store.
// Each accepted item gives one result; a start or a bit may walk on through the entries, and a
// clear item zeroes the whole store first. One item at a time; the next is taken the cycle after
// its result enters the output register; while that register holds an untaken result, the
// sequencer stalls once it reaches its next result.
// Reset (rst_n low, synchronous) runs a zeroing sweep of the store; no item is taken until done.
// Depends on bsd_pkg, bsd_if, bsd_store and bsd_ctrl.
`default_nettype none
module bitplane_significance_decoder #(
  parameter int DEPTH    = bsd_pkg::DEPTH_DEF,
  parameter int MAG_BITS = bsd_pkg::MAG_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  bsd_in_if.sink                                 in_ch,
  bsd_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [bsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bsd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bsd_pkg::*;

  bsd_cfg_t    cfg_r;
  logic        res_valid;
  logic        res_ready;
  bsd_result_t res;
  logic        out_valid_r;
  bsd_result_t out_res_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entry_count <= ENTRY_COUNT_RST;
      cfg_r.bit_plane   <= BIT_PLANE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRY_COUNT: cfg_r.entry_count <= cfg_wdata[COUNT_W-1:0];
        CFG_BIT_PLANE:   cfg_r.bit_plane   <= cfg_wdata[PLANE_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  bsd_ctrl #(
    .DEPTH    (DEPTH),
    .MAG_BITS (MAG_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = out_res_r.value;
  assign out_ch.expect_res = out_res_r.expect_res;
  assign out_ch.position   = out_res_r.position;

endmodule
`default_nettype wire

FILE: tb/bsd_decode_checker.sv
`timescale 1ns / 1ps
// Checker for the bit-plane significance decoder: mirrors the coefficient store and pass state,
// predicts the result of every accepted item and compares it with the result channel.
// Depends on bsd_pkg and the channel interfaces bsd_in_if and bsd_out_if.
module bsd_decode_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  bsd_in_if                              in_mon,
  bsd_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [bsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             results_owed,
  output int                             results_checked
);
  import bsd_pkg::*;

  localparam int NUM_ENTRIES = DEPTH_DEF;
  localparam int MAG         = MAG_BITS_DEF;
  localparam int SIGN_BIT    = MAG;
  localparam int SIG_BIT     = MAG + 1;
  localparam int REF_BIT     = MAG + 2;
  localparam int PRINT_CAP   = 100;

  typedef logic [MAG+2:0] coef_t;
  typedef enum logic [1:0] {PH_IDLE, PH_SIG, PH_SIGN, PH_REF} decode_phase_e;

  coef_t              coef_mem [NUM_ENTRIES];
  decode_phase_e      phase;
  int                 walk_pos;
  logic [COUNT_W-1:0] count_reg;
  logic [PLANE_W-1:0] plane_reg;
  bsd_result_t        coef_results_due [$];

  // Entries covered by a pass: the count, capped at the store depth
  function automatic int active_len();
    return (int'(count_reg) > NUM_ENTRIES) ? NUM_ENTRIES : int'(count_reg);
  endfunction

  // Place a decoded bit at the configured plane; planes past the magnitude drop it
  function automatic coef_t plane_mag(input logic b);
    coef_t m;
    m = '0;
    if (int'(plane_reg) < MAG) m[plane_reg] = b;
    return m;
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < NUM_ENTRIES; i++) coef_mem[i] = '0;
    phase    = PH_IDLE;
    walk_pos = 0;
  endfunction

  // Promote significant entries until one needs a refinement bit, else close the pass
  function automatic void finish_refine();
    int n;
    n = active_len();
    while (walk_pos < n) begin
      if (coef_mem[walk_pos][REF_BIT]) return;
      if (coef_mem[walk_pos][SIG_BIT]) begin
        coef_mem[walk_pos][SIG_BIT] = 1'b0;
        coef_mem[walk_pos][REF_BIT] = 1'b1;
      end
      walk_pos++;
    end
    phase    = PH_IDLE;
    walk_pos = n;
  endfunction

  // Skip refining entries; at the end of the first sub-pass move on to refinement
  function automatic void seek_significance();
    int n;
    n = active_len();
    while (walk_pos < n && coef_mem[walk_pos][REF_BIT]) walk_pos++;
    if (walk_pos < n) return;
    phase    = PH_REF;
    walk_pos = 0;
    finish_refine();
  endfunction

  // Apply one item to the mirrored store and build the result it should produce
  function automatic bsd_result_t decode_item(input logic [MODE_W-1:0] mode, input logic b,
                                              input logic [INDEX_W-1:0] idx);
    bsd_result_t        r;
    coef_t              e;
    logic [VALUE_W-1:0] v;
    v = '0;
    case (mode)
      MODE_START: begin
        phase    = PH_SIG;
        walk_pos = 0;
        seek_significance();
      end
      MODE_BIT: begin
        if (phase != PH_IDLE && walk_pos >= active_len()) begin
          if (phase == PH_REF) begin
            finish_refine();
          end else begin
            phase = PH_SIG;
            seek_significance();
          end
        end else if (phase == PH_SIG) begin
          coef_mem[walk_pos] |= plane_mag(b);
          if (b) begin
            phase = PH_SIGN;
          end else begin
            walk_pos++;
            seek_significance();
          end
        end else if (phase == PH_SIGN) begin
          coef_mem[walk_pos][SIG_BIT] = 1'b1;
          if (b) coef_mem[walk_pos][SIGN_BIT] = 1'b1;
          phase = PH_SIG;
          walk_pos++;
          seek_significance();
        end else if (phase == PH_REF) begin
          coef_mem[walk_pos] |= plane_mag(b);
          walk_pos++;
          finish_refine();
        end
      end
      MODE_READ: begin
        if (int'(idx) < NUM_ENTRIES) begin
          e = coef_mem[idx];
          v = VALUE_W'(e[MAG-1:0]);
          if (e[SIGN_BIT]) v = -v;
        end
      end
      MODE_CLEAR: begin
        clear_store();
      end
    endcase
    r.value = v;
    case (phase)
      PH_SIG:  r.expect_res = EXP_SIG;
      PH_SIGN: r.expect_res = EXP_SIGN;
      PH_REF:  r.expect_res = EXP_REF;
      default: r.expect_res = EXP_NONE;
    endcase
    r.position = POS_W'(walk_pos);
    return r;
  endfunction

  // Print one line per mismatch (up to a cap) and count every one
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] result %0d: %s is %0d, predicted %0d", $time, results_checked, what,
               got, want);
  endtask

  // Track config writes, check results against the oldest prediction, queue new predictions
  always @(posedge clk) begin : track
    bsd_result_t want;
    if (!rst_n) begin
      clear_store();
      count_reg = ENTRY_COUNT_RST;
      plane_reg = BIT_PLANE_RST;
      coef_results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENTRY_COUNT: count_reg = cfg_wdata[COUNT_W-1:0];
          CFG_BIT_PLANE:   plane_reg = cfg_wdata[PLANE_W-1:0];
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (coef_results_due.size() == 0) begin
          report_mismatch("unexpected result, value", int'(out_mon.value), 0);
        end else begin
          want = coef_results_due.pop_front();
          if (out_mon.value !== want.value)
            report_mismatch("value", int'(out_mon.value), int'(want.value));
          if (out_mon.expect_res !== want.expect_res)
            report_mismatch("expect_res", int'(out_mon.expect_res), int'(want.expect_res));
          if (out_mon.position !== want.position)
            report_mismatch("position", int'(out_mon.position), int'(want.position));
          results_checked++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        coef_results_due.push_back(decode_item(in_mon.mode, in_mon.bit_req, in_mon.index));
    end
    results_owed <= coef_results_due.size();
  end

endmodule

FILE: tb/tb_bitplane_significance_decoder.sv
`timescale 1ns / 1ps
// Top of the bit-plane significance decoder bench: clock, reset, item and config stimulus.
// Depends on bsd_pkg, bsd_if, the decoder RTL and bsd_decode_checker.
module tb_bitplane_significance_decoder;
  import bsd_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RUN_LIMIT_NS = 40_000_000;
  localparam int TARGET_ITEMS = 1750;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 64;
  localparam int NUM_ENTRIES  = DEPTH_DEF;
  localparam int MAX_BITS     = 80;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_tickets;
  int items_sent;
  int mode_seen [4];
  int fail_count;
  int results_owed;
  int results_checked;

  bsd_in_if  in_ch ();
  bsd_out_if out_ch ();

  bitplane_significance_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bsd_decode_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (fail_count),
    .results_owed    (results_owed),
    .results_checked (results_checked)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Take results at random; on a new hold request stall for a long stretch
  initial begin : result_taker
    int served;
    int hold_left;
    served       = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_tickets != served) begin
        served    = hold_tickets;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Timeout: %0d items sent, %0d results still owed", items_sent, results_owed);
    $display("Some tests failed");
    $finish;
  end

  // Offer one item after random idle cycles and hold it until accepted
  task automatic put_item(input logic [MODE_W-1:0] m, input int b, input int idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= m;
    in_ch.bit_req <= b[0];
    in_ch.index   <= INDEX_W'(idx);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    mode_seen[m]++;
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // Write both registers back to back; call only while the block is idle
  task automatic set_config(input int count, input int plane);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENTRY_COUNT;
    cfg_wdata <= CFG_DATA_W'(count);
    @(posedge clk);
    cfg_index <= CFG_BIT_PLANE;
    cfg_wdata <= CFG_DATA_W'(plane);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int tx, input int rx);
    tx_idle_pct = tx;
    rx_idle_pct <= rx;
  endtask

  // Mostly an entry inside the pass, sometimes anywhere in the store
  function automatic logic [INDEX_W-1:0] pick_index(input int span);
    if (span == 0 || $urandom_range(99) < 20) return INDEX_W'($urandom_range(NUM_ENTRIES - 1));
    return INDEX_W'($urandom_range(span - 1));
  endfunction

  // Mostly short passes; now and then zero, the depth and counts past it
  function automatic int pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 2) return 0;
    if (r < 4) return (1 << CFG_DATA_W) - 1;
    if (r < 6) return NUM_ENTRIES;
    if (r < 8) return $urandom_range(NUM_ENTRIES + 1, (1 << CFG_DATA_W) - 2);
    if (r < 70) return $urandom_range(1, 16);
    return $urandom_range(17, 64);
  endfunction

  // One pass: configure, start, feed roughly the bits it needs, then read back
  task automatic run_pass(input int count, input int plane, input int ones_pct);
    int span;
    int nbits;
    int r;
    drain();
    set_config(count, plane);
    put_item(MODE_START, $urandom_range(1), $urandom_range(NUM_ENTRIES - 1));
    span  = (count > NUM_ENTRIES) ? NUM_ENTRIES : count;
    nbits = span + span * ones_pct / 100 + $urandom_range(2);
    if (nbits > MAX_BITS) nbits = MAX_BITS;
    for (int i = 0; i < nbits; i++) begin
      r = $urandom_range(99);
      if (r < 3)
        put_item(MODE_READ, $urandom_range(1), pick_index(span));
      else if (r == 3)
        put_item(MODE_START, $urandom_range(1), $urandom_range(NUM_ENTRIES - 1));
      else
        put_item(MODE_BIT, $urandom_range(99) < ones_pct, $urandom_range(NUM_ENTRIES - 1));
    end
    repeat ($urandom_range(1, 3)) put_item(MODE_READ, $urandom_range(1), pick_index(span));
  endtask

  initial begin : stimulus
    int count;
    int plane_top;
    int passes;
    int ones_pct;
    int episode;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_ENTRY_COUNT;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.mode    = MODE_START;
    in_ch.bit_req = 1'b0;
    in_ch.index   = '0;
    tx_idle_pct   = 34;
    rx_idle_pct   = 62;
    hold_tickets  = 0;
    items_sent    = 0;
    foreach (mode_seen[i]) mode_seen[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Bit with no pass open, then reads of the empty store at both ends
    put_item(MODE_BIT, 1'b1, '1);
    put_item(MODE_READ, 1'b0, '0);
    put_item(MODE_READ, 1'b1, '1);

    // Single entry at the top plane: significant and negative, then refined at plane zero
    drain();
    set_config(1, 15);
    put_item(MODE_START, 1'b1, 12'hAAA);
    put_item(MODE_BIT, 1'b1, 12'h555);
    put_item(MODE_BIT, 1'b1, '0);
    drain();
    set_config(1, 0);
    put_item(MODE_START, 1'b0, 12'h555);
    put_item(MODE_BIT, 1'b1, 12'hAAA);
    put_item(MODE_READ, 1'b0, '0);

    // Zero count closes the pass at once; the next bit is ignored
    drain();
    set_config(0, 7);
    put_item(MODE_START, 1'b0, '0);
    put_item(MODE_BIT, 1'b1, '0);

    // Count past the depth; abandon the pass with a new start, then clear mid pass
    drain();
    set_config((1 << CFG_DATA_W) - 1, 3);
    put_item(MODE_START, 1'b0, '0);
    put_item(MODE_BIT, 1'b0, '0);
    put_item(MODE_BIT, 1'b1, '0);
    put_item(MODE_BIT, 1'b0, '0);
    put_item(MODE_READ, 1'b0, 12'd1);
    put_item(MODE_START, 1'b1, '1);
    put_item(MODE_BIT, 1'b1, '0);
    put_item(MODE_CLEAR, 1'b1, '1);
    put_item(MODE_BIT, 1'b1, '0);
    put_item(MODE_READ, 1'b1, 12'd1);

    // Count equal to the depth, read of the last entry
    drain();
    set_config(NUM_ENTRIES, 9);
    put_item(MODE_START, 1'b0, '0);
    put_item(MODE_BIT, 1'b1, '0);
    put_item(MODE_BIT, 1'b1, '0);
    put_item(MODE_READ, 1'b0, '1);

    // Long result stall while reads keep coming, so the block backs up
    drain();
    hold_tickets <= hold_tickets + 1;
    repeat (30) put_item(MODE_READ, $urandom_range(1), $urandom_range(NUM_ENTRIES - 1));
    drain();

    // Episodes of passes over descending planes, switching idle pattern by thirds
    episode = 0;
    while (items_sent < TARGET_ITEMS) begin
      if (items_sent >= 2 * TARGET_ITEMS / 3) set_idling(0, 0);
      else if (items_sent >= TARGET_ITEMS / 3) set_idling(62, 34);
      if (episode == 0) begin
        // every plane of two entries set, driving the magnitude to its maximum
        count     = 2;
        plane_top = 15;
        passes    = 16;
        ones_pct  = 100;
      end else begin
        count     = pick_count();
        plane_top = $urandom_range(15);
        passes    = $urandom_range(1, 6);
        ones_pct  = $urandom_range(5, 70);
      end
      if ($urandom_range(7) == 0)
        put_item(MODE_CLEAR, $urandom_range(1), $urandom_range(NUM_ENTRIES - 1));
      for (int p = 0; p < passes && p <= plane_top && items_sent < TARGET_ITEMS; p++)
        run_pass(count, plane_top - p, ones_pct);
      episode++;
    end

    // Let everything come back, then watch a while for stray results
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d items (%0d starts, %0d bits, %0d reads, %0d clears) in %0d episodes.",
             items_sent, mode_seen[MODE_START], mode_seen[MODE_BIT], mode_seen[MODE_READ],
             mode_seen[MODE_CLEAR], episode);
    $display("Compared %0d results, %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
